[hdl/encoder_velocity_pid_core_assert.svh]
// Assertion macros for the encoder velocity PID core.
// Included by the top level; needs no package.
`ifndef ENCODER_VELOCITY_PID_CORE_ASSERT_SVH
`define ENCODER_VELOCITY_PID_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define EVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EVP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define EVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/evp_pkg.sv]
// Shared constants, configuration layout and inter-module structs
// for the encoder velocity PID core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package evp_pkg;

   localparam int EDGE_COUNT_BITS_DEF = 16;
   localparam int PWM_BITS_DEF        = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int CPR_BITS       = 16;
   localparam int GAIN_BITS      = 16;
   localparam int INTEG_BITS     = 32;
   localparam int INTEG_MAX_BITS = 31;
   localparam int LIMIT_BITS     = 8;
   localparam int TARGET_BITS    = 16;
   localparam int Q_FRAC_BITS    = 8;
   localparam int SPEED_BITS     = 24;
   localparam int POS_BITS       = 17;
   localparam int REV_BITS       = 32;

   // bit-serial multiply-accumulate
   localparam int MUL_BITS    = GAIN_BITS;
   localparam int MAC_LANES   = 3;
   localparam int MAC_OP_BITS = 32;
   localparam int MAC_HI_BITS = MAC_OP_BITS + 3;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS-1){1'b1}}};
   localparam logic [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COUNTS_PER_REV = 3'd0,
      CSR_SPEED_SCALE    = 3'd1,
      CSR_GAIN_P         = 3'd2,
      CSR_GAIN_I         = 3'd3,
      CSR_GAIN_D         = 3'd4,
      CSR_INTEGRAL_MIN   = 3'd5,
      CSR_INTEGRAL_MAX   = 3'd6,
      CSR_PWM_LIMIT      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CPR_BITS-1:0]       counts_per_rev;
      logic [GAIN_BITS-1:0]      speed_scale;
      logic [GAIN_BITS-1:0]      gain_p;
      logic [GAIN_BITS-1:0]      gain_i;
      logic [GAIN_BITS-1:0]      gain_d;
      logic [INTEG_BITS-1:0]     integral_min;
      logic [INTEG_MAX_BITS-1:0] integral_max;
      logic [LIMIT_BITS-1:0]     pwm_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      counts_per_rev: 16'd983,
      speed_scale:    16'd164,
      gain_p:         16'd10267,
      gain_i:         16'd1467,
      gain_d:         16'd1027,
      integral_min:   -32'sd7333890,
      integral_max:   31'd733386,
      pwm_limit:      8'd255
   };

   typedef struct packed {
      logic                                  start;
      logic [MAC_LANES-1:0][MAC_OP_BITS-1:0] op;
      logic [MAC_LANES-1:0][MUL_BITS-1:0]    gain;
   } mac_cmd_type;

   typedef struct packed {
      logic                          done;
      logic signed [MAC_HI_BITS-1:0] hi;
      logic [MUL_BITS-1:0]           lo;
   } mac_res_type;

   typedef struct packed {
      logic edge_en;
      logic count_up;
      logic tick_clear;
   } enc_ctl_type;

endpackage
`default_nettype wire

[hdl/evp_req_if.sv]
// Input channel of the encoder velocity PID core: valid/ready plus item fields.
// Depends on evp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface evp_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     action;
   logic                                     level_a;
   logic                                     level_b;
   logic signed [evp_pkg::TARGET_BITS-1:0]   target_speed;

   modport source (output valid, action, level_a, level_b, target_speed, input ready);
   modport sink   (input valid, action, level_a, level_b, target_speed, output ready);
endinterface
`default_nettype wire

[hdl/evp_rsp_if.sv]
// Result channel of the encoder velocity PID core: valid/ready plus result fields.
// Depends on evp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface evp_rsp_if #(
   parameter int PWM_BITS = evp_pkg::PWM_BITS_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic [PWM_BITS-1:0]                    pwm_duty;
   logic                                   forward;
   logic signed [evp_pkg::SPEED_BITS-1:0]  measured_speed;
   logic signed [evp_pkg::REV_BITS-1:0]    revolution_count;
   logic signed [evp_pkg::POS_BITS-1:0]    position_in_rev;

   modport source (output valid, pwm_duty, forward, measured_speed, revolution_count,
                   position_in_rev, input ready);
   modport sink   (input valid, pwm_duty, forward, measured_speed, revolution_count,
                   position_in_rev, output ready);
endinterface
`default_nettype wire

[hdl/encoder_velocity_pid_core.sv]
// Encoder velocity PID core. An encoder edge item is taken and yields no
// result; the core is ready for the next item on the following cycle.
// A control tick item yields one result; the core takes no new item until that
// result is registered, and holds longer while an earlier result still waits
// in the output register. The time to that result is set by two passes of the
// bit-serial multiply-accumulate unit (measured speed, then the PID sum), one
// gain bit per cycle. A finished result waits in an output register, so edges
// keep being counted while it is not yet taken. Depends on evp_pkg, the channel
// interfaces and encoder_velocity_pid_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_velocity_pid_core_assert.svh"
module encoder_velocity_pid_core #(
   parameter int EDGE_COUNT_BITS = evp_pkg::EDGE_COUNT_BITS_DEF,
   parameter int PWM_BITS        = evp_pkg::PWM_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   evp_req_if.sink                                   req,
   evp_rsp_if.source                                 rsp,
   input  wire logic                                 csr_write_en,
   input  wire logic [evp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [evp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   localparam int OPW = evp_pkg::MAC_OP_BITS;

   evp_pkg::cfg_type     cfg_ff, cfg_in;
   evp_pkg::enc_ctl_type enc_ctl;
   evp_pkg::mac_cmd_type mac_cmd;
   evp_pkg::mac_res_type mac_res;

   logic signed [evp_pkg::POS_BITS-1:0] rev_position;
   logic signed [evp_pkg::REV_BITS-1:0] revolutions;
   logic signed [EDGE_COUNT_BITS-1:0]   tick_edges;
   logic signed [OPW-1:0]               tick_edges_ext;
   logic                                pid_idle, item_take, tick_go;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (evp_pkg::csr_index_type'(csr_index))
            evp_pkg::CSR_COUNTS_PER_REV: cfg_in.counts_per_rev = csr_wdata[15:0];
            evp_pkg::CSR_SPEED_SCALE:    cfg_in.speed_scale    = csr_wdata[15:0];
            evp_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata[15:0];
            evp_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata[15:0];
            evp_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata[15:0];
            evp_pkg::CSR_INTEGRAL_MIN:   cfg_in.integral_min   = csr_wdata[31:0];
            evp_pkg::CSR_INTEGRAL_MAX:   cfg_in.integral_max   = csr_wdata[30:0];
            evp_pkg::CSR_PWM_LIMIT:      cfg_in.pwm_limit      = csr_wdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= evp_pkg::CFG_RESET;
      else cfg_ff <= cfg_in;
   end

   assign req.ready          = pid_idle;
   assign item_take          = req.valid && pid_idle;
   assign tick_go            = item_take && req.action;
   assign enc_ctl.edge_en    = item_take && !req.action;
   assign enc_ctl.count_up   = (req.level_a == req.level_b);
   assign enc_ctl.tick_clear = tick_go;
   assign tick_edges_ext     = OPW'(tick_edges);

   evp_encoder_count #(
      .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
   ) u_count (
      .clock          (clock),
      .reset          (reset),
      .ctl            (enc_ctl),
      .counts_per_rev (cfg_ff.counts_per_rev),
      .rev_position   (rev_position),
      .revolutions    (revolutions),
      .tick_edges     (tick_edges)
   );

   evp_serial_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_cmd (mac_cmd),
      .mac_res (mac_res)
   );

   evp_pid_ctrl #(
      .PWM_BITS (PWM_BITS)
   ) u_pid (
      .clock            (clock),
      .reset            (reset),
      .tick_go          (tick_go),
      .target_speed     (req.target_speed),
      .tick_edges       (tick_edges_ext),
      .cfg              (cfg_ff),
      .rev_position     (rev_position),
      .revolutions      (revolutions),
      .mac_cmd          (mac_cmd),
      .mac_res          (mac_res),
      .idle             (pid_idle),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .pwm_duty         (rsp.pwm_duty),
      .forward          (rsp.forward),
      .measured_speed   (rsp.measured_speed),
      .revolution_count (rsp.revolution_count),
      .position_in_rev  (rsp.position_in_rev)
   );

   `EVP_ASSERT_NEXT(a_tick_busy, clock, reset, tick_go, !req.ready, "core ready after tick")
   `EVP_ASSERT_NEXT(a_tick_clear, clock, reset, tick_go, tick_edges == '0, "tick edges kept")
   `EVP_ASSERT_NOW(a_mac_idle, clock, reset, mac_res.done, !req.ready, "mac done while idle")
endmodule
`default_nettype wire

[hdl/evp_encoder_count.sv]
// Quadrature edge counter: position within a revolution, revolution count
// and saturating per-tick edge sum. Depends on evp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module evp_encoder_count #(
   parameter int EDGE_COUNT_BITS = evp_pkg::EDGE_COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire evp_pkg::enc_ctl_type               ctl,
   input  wire logic [evp_pkg::CPR_BITS-1:0]       counts_per_rev,
   output logic signed [evp_pkg::POS_BITS-1:0]     rev_position,
   output logic signed [evp_pkg::REV_BITS-1:0]     revolutions,
   output logic signed [EDGE_COUNT_BITS-1:0]       tick_edges
);
   localparam int PW  = evp_pkg::POS_BITS + 1;
   localparam int CPW = evp_pkg::CPR_BITS;
   localparam int RW  = evp_pkg::REV_BITS;
   localparam logic [EDGE_COUNT_BITS-1:0] EDGE_MAX = {1'b0, {(EDGE_COUNT_BITS-1){1'b1}}};
   localparam logic [EDGE_COUNT_BITS-1:0] EDGE_MIN = {1'b1, {(EDGE_COUNT_BITS-1){1'b0}}};

   logic [evp_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic [RW-1:0]                rev_ff, rev_in;
   logic [EDGE_COUNT_BITS-1:0]   edges_ff, edges_in;

   logic [CPW-1:0]       cpr_eff;
   logic signed [PW-1:0] cpr_s, pos_ext, pos_step;

   always_comb begin
      // a zero revolution length counts as one
      cpr_eff  = (counts_per_rev == '0) ? CPW'(1) : counts_per_rev;
      cpr_s    = $signed({{(PW-CPW){1'b0}}, cpr_eff});
      pos_ext  = $signed({pos_ff[evp_pkg::POS_BITS-1], pos_ff});
      pos_step = ctl.count_up ? pos_ext + PW'(1) : pos_ext - PW'(1);

      pos_in   = pos_ff;
      rev_in   = rev_ff;
      edges_in = edges_ff;
      if (ctl.edge_en) begin
         // one wrap step per edge
         if (pos_step >= cpr_s) begin
            pos_in = evp_pkg::POS_BITS'(pos_step - cpr_s);
            rev_in = rev_ff + RW'(1);
         end else if (pos_step <= -cpr_s) begin
            pos_in = evp_pkg::POS_BITS'(pos_step + cpr_s);
            rev_in = rev_ff - RW'(1);
         end else begin
            pos_in = evp_pkg::POS_BITS'(pos_step);
         end
         if (ctl.count_up) begin
            if (edges_ff != EDGE_MAX) edges_in = edges_ff + EDGE_COUNT_BITS'(1);
         end else begin
            if (edges_ff != EDGE_MIN) edges_in = edges_ff - EDGE_COUNT_BITS'(1);
         end
      end
      if (ctl.tick_clear) edges_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rev_ff   <= '0;
         edges_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         rev_ff   <= rev_in;
         edges_ff <= edges_in;
      end
   end

   assign rev_position = $signed(pos_ff);
   assign revolutions  = $signed(rev_ff);
   assign tick_edges   = $signed(edges_ff);
endmodule
`default_nettype wire

[hdl/evp_serial_mac.sv]
// Bit-serial multiply-accumulate: sum of three signed operands times
// unsigned 16-bit gains, one gain bit per cycle. Depends on evp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module evp_serial_mac (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire evp_pkg::mac_cmd_type mac_cmd,
   output evp_pkg::mac_res_type      mac_res
);
   localparam int MB  = evp_pkg::MUL_BITS;
   localparam int OPW = evp_pkg::MAC_OP_BITS;
   localparam int HW  = evp_pkg::MAC_HI_BITS;
   localparam int NL  = evp_pkg::MAC_LANES;
   localparam int CW  = $clog2(MB);

   logic                     busy_ff, done_ff;
   logic [CW-1:0]            cnt_ff;
   logic signed [HW-1:0]     hi_ff;
   logic [MB-1:0]            lo_ff;
   logic [NL-1:0][OPW-1:0]   op_ff;
   logic [NL-1:0][MB-1:0]    gain_ff;

   logic signed [HW-1:0] term_sum, acc_in;

   always_comb begin
      term_sum = '0;
      for (int l = 0; l < NL; l++) begin
         if (gain_ff[l][0]) term_sum = term_sum + HW'($signed(op_ff[l]));
      end
      acc_in = hi_ff + term_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mac_cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            hi_ff   <= '0;
            lo_ff   <= '0;
            op_ff   <= mac_cmd.op;
            gain_ff <= mac_cmd.gain;
         end else if (busy_ff) begin
            // add the selected operands, then shift the accumulator right
            hi_ff  <= acc_in >>> 1;
            lo_ff  <= {acc_in[0], lo_ff[MB-1:1]};
            for (int l = 0; l < NL; l++) gain_ff[l] <= {1'b0, gain_ff[l][MB-1:1]};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(MB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mac_res.done = done_ff;
   assign mac_res.hi   = hi_ff;
   assign mac_res.lo   = lo_ff;
endmodule
`default_nettype wire

[hdl/evp_pid_ctrl.sv]
// Tick sequencer: measured speed, error, clamped integral, derivative,
// PID sum through the serial MAC, saturation and the result register. Depends on evp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module evp_pid_ctrl #(
   parameter int PWM_BITS = evp_pkg::PWM_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   tick_go,
   input  wire logic signed [evp_pkg::TARGET_BITS-1:0] target_speed,
   input  wire logic signed [evp_pkg::MAC_OP_BITS-1:0] tick_edges,
   input  wire evp_pkg::cfg_type                       cfg,
   input  wire logic signed [evp_pkg::POS_BITS-1:0]    rev_position,
   input  wire logic signed [evp_pkg::REV_BITS-1:0]    revolutions,
   output evp_pkg::mac_cmd_type                        mac_cmd,
   input  wire evp_pkg::mac_res_type                   mac_res,
   output logic                                        idle,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [PWM_BITS-1:0]                         pwm_duty,
   output logic                                        forward,
   output logic signed [evp_pkg::SPEED_BITS-1:0]       measured_speed,
   output logic signed [evp_pkg::REV_BITS-1:0]         revolution_count,
   output logic signed [evp_pkg::POS_BITS-1:0]         position_in_rev
);
   localparam int SB  = evp_pkg::SPEED_BITS;
   localparam int TB  = evp_pkg::TARGET_BITS;
   localparam int QF  = evp_pkg::Q_FRAC_BITS;
   localparam int IB  = evp_pkg::INTEG_BITS;
   localparam int IMB = evp_pkg::INTEG_MAX_BITS;
   localparam int OPW = evp_pkg::MAC_OP_BITS;
   localparam int HW  = evp_pkg::MAC_HI_BITS;
   localparam int MB  = evp_pkg::MUL_BITS;
   localparam int LB  = evp_pkg::LIMIT_BITS;
   localparam int PB  = HW + MB;
   localparam int DB  = SB + 1;
   localparam int SUMB = IB + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MEAS, ST_ERROR, ST_INTEG, ST_CLAMP, ST_SUM, ST_LIMIT
   } state_type;

   state_type            state_ff;
   logic [TB-1:0]        target_ff;
   logic [SB-1:0]        meas_ff, err_ff, prev_ff;
   logic [DB-1:0]        deriv_ff;
   logic [SUMB-1:0]      isum_ff;
   logic [IB-1:0]        integ_ff;
   logic [HW-1:0]        mag_ff;
   logic                 neg_ff, dir_ff;
   logic                 rsp_valid_ff;
   logic [PWM_BITS-1:0]  duty_ff;
   logic                 fwd_ff;
   logic [SB-1:0]        meas_out_ff;
   logic [evp_pkg::REV_BITS-1:0] rev_out_ff;
   logic [evp_pkg::POS_BITS-1:0] pos_out_ff;

   logic [PB-1:0]        prod;
   logic [PB-SB:0]       prod_top;
   logic [SB-1:0]        meas_in, err_in;
   logic signed [DB-1:0] err_wide, deriv_in;
   logic signed [SUMB-1:0] isum_in, imin_ext, imax_ext;
   logic [IB-1:0]        integ_in;
   logic [HW-1:0]        mag_in;
   logic [LB-1:0]        duty_sel;
   logic                 rsp_free;

   always_comb begin
      prod     = {mac_res.hi, mac_res.lo};
      prod_top = prod[PB-1:SB-1];
      if ((&prod_top) || !(|prod_top)) meas_in = prod[SB-1:0];
      else meas_in = prod[PB-1] ? evp_pkg::SPEED_MIN : evp_pkg::SPEED_MAX;

      err_wide = $signed({target_ff[TB-1], target_ff, {QF{1'b0}}})
               - $signed({meas_ff[SB-1], meas_ff});
      if (err_wide[DB-1] == err_wide[DB-2]) err_in = err_wide[SB-1:0];
      else err_in = err_wide[DB-1] ? evp_pkg::SPEED_MIN : evp_pkg::SPEED_MAX;

      isum_in  = $signed({integ_ff[IB-1], integ_ff})
               + $signed({{(SUMB-SB){err_ff[SB-1]}}, err_ff});
      deriv_in = $signed({err_ff[SB-1], err_ff}) - $signed({prev_ff[SB-1], prev_ff});

      // lower bound is tested first; when the bounds cross, a sum below it takes the lower bound
      imin_ext = $signed({cfg.integral_min[IB-1], cfg.integral_min});
      imax_ext = $signed({{(SUMB-IMB){1'b0}}, cfg.integral_max});
      if ($signed(isum_ff) < imin_ext) integ_in = cfg.integral_min;
      else if ($signed(isum_ff) > imax_ext) integ_in = {{(IB-IMB){1'b0}}, cfg.integral_max};
      else integ_in = isum_ff[IB-1:0];

      // magnitude of the Q16 sum shifted right, truncated toward zero
      if (mac_res.hi[HW-1]) mag_in = (|mac_res.lo) ? ~mac_res.hi : -mac_res.hi;
      else mag_in = mac_res.hi;

      duty_sel = (mag_ff > HW'(cfg.pwm_limit)) ? cfg.pwm_limit : mag_ff[LB-1:0];
      rsp_free = !rsp_valid_ff || rsp_ready;

      mac_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (tick_go) begin
               mac_cmd.start   = 1'b1;
               mac_cmd.op[0]   = tick_edges;
               mac_cmd.gain[0] = cfg.speed_scale;
            end
         end
         ST_CLAMP: begin
            mac_cmd.start   = 1'b1;
            mac_cmd.op[0]   = OPW'($signed(err_ff));
            mac_cmd.op[1]   = integ_in;
            mac_cmd.op[2]   = OPW'($signed(deriv_ff));
            mac_cmd.gain[0] = cfg.gain_p;
            mac_cmd.gain[1] = cfg.gain_i;
            mac_cmd.gain[2] = cfg.gain_d;
         end
         default: mac_cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         dir_ff       <= 1'b1;
      end else begin
         // the result stage reloads the register itself when it is free
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_LIMIT)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (tick_go) begin
                  target_ff <= target_speed;
                  state_ff  <= ST_MEAS;
               end
            end
            ST_MEAS: begin
               if (mac_res.done) begin
                  meas_ff  <= meas_in;
                  state_ff <= ST_ERROR;
               end
            end
            ST_ERROR: begin
               err_ff   <= err_in;
               state_ff <= ST_INTEG;
            end
            ST_INTEG: begin
               isum_ff  <= isum_in;
               deriv_ff <= deriv_in;
               prev_ff  <= err_ff;
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               integ_ff <= integ_in;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (mac_res.done) begin
                  mag_ff   <= mag_in;
                  neg_ff   <= mac_res.hi[HW-1];
                  state_ff <= ST_LIMIT;
               end
            end
            ST_LIMIT: begin
               // hold until the result register is free
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  duty_ff      <= PWM_BITS'(duty_sel);
                  fwd_ff       <= (duty_sel != '0) ? !neg_ff : dir_ff;
                  if (duty_sel != '0) dir_ff <= !neg_ff;
                  meas_out_ff  <= meas_ff;
                  rev_out_ff   <= revolutions;
                  pos_out_ff   <= rev_position;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign idle             = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign pwm_duty         = duty_ff;
   assign forward          = fwd_ff;
   assign measured_speed   = $signed(meas_out_ff);
   assign revolution_count = $signed(rev_out_ff);
   assign position_in_rev  = $signed(pos_out_ff);
endmodule
`default_nettype wire
